### design/ptree_pkg.sv
// Shared constants and types for the palindromic tree append block.
package ptree_pkg;

   localparam int MAX_LEN     = 4096;
   localparam int ALPHABET    = 26;
   localparam int NODE_CAP    = MAX_LEN + 2;
   localparam int TEXT_DEPTH  = MAX_LEN + 1;
   localparam int CHILD_DEPTH = NODE_CAP * ALPHABET;

   localparam int SYM_W    = 5;
   localparam int OUT_W    = 13;
   localparam int NODE_W   = $clog2(NODE_CAP);
   localparam int TEXT_AW  = $clog2(TEXT_DEPTH);
   localparam int LEN_W    = TEXT_AW + 1;
   localparam int BACK_W   = LEN_W + 1;
   localparam int CHILD_AW = $clog2(CHILD_DEPTH);
   localparam int TAG_W    = 4;

   localparam logic [NODE_W-1:0] ROOT_EVEN = NODE_W'(0);
   localparam logic [NODE_W-1:0] ROOT_ODD  = NODE_W'(1);

   // Kind of result loaded into the output register.
   typedef enum logic [1:0] {
      RES_OVF,
      RES_OLD,
      RES_NEW
   } res_kind_type;

   // Source of the node memory read address.
   typedef enum logic [1:0] {
      NSRC_V,
      NSRC_NODE,
      NSRC_LINK
   } node_src_type;

   typedef struct packed {
      logic         capture;
      logic         do_restart;
      logic         clear_start;
      logic         clear_wr;
      logic         start_item;
      logic         rd_node;
      node_src_type node_src;
      logic         rd_text;
      logic         follow_link;
      logic         set_cur;
      logic         calc_key;
      logic         rd_child;
      logic         take_child;
      logic         create;
      logic         walk_up;
      logic         take_link;
      logic         commit;
      logic         load_rsp;
      res_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic restart;
      logic wrap;
      logic clear_last;
      logic bad;
      logic len_root;
      logic back_ok;
      logic text_match;
      logic child_hit;
      logic cur_odd;
   } sts_type;

endpackage

### design/ptree_dp.sv
// Datapath of the palindromic tree: memories, walk registers and result register.
module ptree_dp
   import ptree_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [SYM_W-1:0]    req_symbol,
   input  logic                req_restart,
   input  cmd_type             cmd,
   output sts_type             sts,
   output logic [OUT_W-1:0]    rsp_suffix_count,
   output logic [OUT_W-1:0]    rsp_longest_suffix_len,
   output logic                rsp_new_palindrome,
   output logic                rsp_overflow
);

   // Memories.
   logic [SYM_W-1:0]        text_mem  [TEXT_DEPTH];
   logic signed [LEN_W-1:0] len_mem   [NODE_CAP];
   logic [NODE_W-1:0]       link_mem  [NODE_CAP];
   logic [OUT_W-1:0]        depth_mem [NODE_CAP];
   logic [TAG_W+NODE_W-1:0] child_mem [CHILD_DEPTH];

   // Control registers.
   logic [TEXT_AW-1:0]  text_len_ff, text_len_in;
   logic [NODE_W-1:0]   last_ff, last_in;
   logic [NODE_W-1:0]   total_ff, total_in;
   logic [TAG_W-1:0]    epoch_ff, epoch_in;
   logic [CHILD_AW-1:0] clr_ff, clr_in;

   // Payload registers.
   logic [SYM_W-1:0]        sym_ff;
   logic                    restart_ff;
   logic [NODE_W-1:0]       v_ff, cur_ff, link_cur_ff, node_ff, link_ff;
   logic signed [LEN_W-1:0] newlen_ff;
   logic [CHILD_AW-1:0]     key_ff, key0_ff;
   logic [OUT_W-1:0]        cnt_ff, lsl_ff;
   logic                    newp_ff, ovf_ff;

   // Read data registers.
   logic [SYM_W-1:0]        text_q;
   logic signed [LEN_W-1:0] len_q;
   logic [NODE_W-1:0]       link_q;
   logic [OUT_W-1:0]        depth_q;
   logic [TAG_W+NODE_W-1:0] child_q;
   logic                    root_q, odd_q;

   logic [NODE_W-1:0]       node_addr;
   logic signed [LEN_W-1:0] len_rd;
   logic [NODE_W-1:0]       link_rd;
   logic [OUT_W-1:0]        depth_rd;
   logic signed [BACK_W-1:0] back;
   logic [TEXT_AW-1:0]      text_next;
   logic                    child_valid;

   // Node read address selection.
   always_comb begin
      case (cmd.node_src)
         NSRC_NODE: node_addr = node_ff;
         NSRC_LINK: node_addr = link_ff;
         default:   node_addr = v_ff;
      endcase
   end

   // The two roots are constants and never live in the memories.
   assign len_rd   = root_q ? (odd_q ? -LEN_W'(1) : LEN_W'(0)) : len_q;
   assign link_rd  = root_q ? ROOT_ODD : link_q;
   assign depth_rd = root_q ? OUT_W'(0) : depth_q;

   assign back = $signed({{(BACK_W-TEXT_AW){1'b0}}, text_len_ff})
               - $signed({len_rd[LEN_W-1], len_rd}) - BACK_W'(1);
   assign text_next   = text_len_ff + TEXT_AW'(1);
   assign child_valid = (child_q[TAG_W+NODE_W-1:NODE_W] == epoch_ff)
                      && (child_q[NODE_W-1:0] != NODE_W'(0));

   // Status toward the controller.
   always_comb begin
      sts.restart    = restart_ff;
      sts.wrap       = (epoch_ff == {TAG_W{1'b1}});
      sts.clear_last = (clr_ff == CHILD_AW'(CHILD_DEPTH - 1));
      sts.bad        = (sym_ff == SYM_W'(0)) || (sym_ff > SYM_W'(ALPHABET))
                     || (text_len_ff >= TEXT_AW'(MAX_LEN))
                     || (total_ff >= NODE_W'(NODE_CAP));
      sts.len_root   = (len_rd == -LEN_W'(1));
      sts.back_ok    = !back[BACK_W-1] && (back != BACK_W'(0));
      sts.text_match = (text_q == sym_ff);
      sts.child_hit  = child_valid;
      sts.cur_odd    = (cur_ff == ROOT_ODD);
   end

   // Next values of the control registers.
   always_comb begin
      text_len_in = text_len_ff;
      last_in     = last_ff;
      total_in    = total_ff;
      epoch_in    = epoch_ff;
      clr_in      = clr_ff;
      if (cmd.do_restart) begin
         text_len_in = TEXT_AW'(0);
         last_in     = ROOT_EVEN;
         total_in    = NODE_W'(2);
         epoch_in    = epoch_ff + TAG_W'(1);
      end
      if (cmd.clear_start) begin
         clr_in = CHILD_AW'(0);
      end else if (cmd.clear_wr) begin
         clr_in = clr_ff + CHILD_AW'(1);
      end
      if (cmd.start_item) begin
         text_len_in = text_next;
      end
      if (cmd.take_child) begin
         last_in = child_q[NODE_W-1:0];
      end
      if (cmd.create) begin
         last_in  = total_ff;
         total_in = total_ff + NODE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_len_ff <= TEXT_AW'(0);
         last_ff     <= ROOT_EVEN;
         total_ff    <= NODE_W'(2);
         epoch_ff    <= TAG_W'(0);
         clr_ff      <= CHILD_AW'(0);
      end else begin
         text_len_ff <= text_len_in;
         last_ff     <= last_in;
         total_ff    <= total_in;
         epoch_ff    <= epoch_in;
         clr_ff      <= clr_in;
      end
   end

   // Walk and result payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sym_ff     <= req_symbol;
         restart_ff <= req_restart;
      end
      if (cmd.start_item) begin
         v_ff <= last_ff;
      end
      if (cmd.follow_link) begin
         v_ff <= (link_rd >= NODE_W'(NODE_CAP)) ? ROOT_ODD : link_rd;
      end
      if (cmd.walk_up) begin
         v_ff <= link_cur_ff;
      end
      if (cmd.set_cur) begin
         cur_ff      <= v_ff;
         link_cur_ff <= link_rd;
         newlen_ff   <= len_rd + LEN_W'(2);
      end
      if (cmd.calc_key) begin
         key_ff <= CHILD_AW'(v_ff) * CHILD_AW'(ALPHABET) + CHILD_AW'(sym_ff) - CHILD_AW'(1);
      end
      if (cmd.take_child) begin
         node_ff <= child_q[NODE_W-1:0];
      end
      if (cmd.create) begin
         node_ff <= total_ff;
         key0_ff <= key_ff;
         link_ff <= ROOT_EVEN;
      end
      if (cmd.take_link) begin
         link_ff <= child_valid ? child_q[NODE_W-1:0] : ROOT_EVEN;
      end
      if (cmd.load_rsp) begin
         case (cmd.kind)
            RES_OLD: begin
               cnt_ff  <= depth_rd;
               lsl_ff  <= len_rd[OUT_W-1:0];
               newp_ff <= 1'b0;
               ovf_ff  <= 1'b0;
            end
            RES_NEW: begin
               cnt_ff  <= depth_rd + OUT_W'(1);
               lsl_ff  <= newlen_ff[OUT_W-1:0];
               newp_ff <= 1'b1;
               ovf_ff  <= 1'b0;
            end
            default: begin
               cnt_ff  <= OUT_W'(0);
               lsl_ff  <= OUT_W'(0);
               newp_ff <= 1'b0;
               ovf_ff  <= 1'b1;
            end
         endcase
      end
   end

   // Text memory.
   always_ff @(posedge clock) begin
      if (cmd.start_item) begin
         text_mem[text_next] <= sym_ff;
      end
      if (cmd.rd_text) begin
         text_q <= text_mem[back[TEXT_AW-1:0]];
      end
   end

   // Node memories.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         len_mem[node_ff]   <= newlen_ff;
         link_mem[node_ff]  <= link_ff;
         depth_mem[node_ff] <= depth_rd + OUT_W'(1);
      end
      if (cmd.rd_node) begin
         len_q   <= len_mem[node_addr];
         link_q  <= link_mem[node_addr];
         depth_q <= depth_mem[node_addr];
         root_q  <= (node_addr < NODE_W'(2));
         odd_q   <= (node_addr == ROOT_ODD);
      end
   end

   // Child table, tagged with the string epoch.
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         child_mem[clr_ff] <= '0;
      end else if (cmd.commit) begin
         child_mem[key0_ff] <= {epoch_ff, node_ff};
      end
      if (cmd.rd_child) begin
         child_q <= child_mem[key_ff];
      end
   end

   assign rsp_suffix_count       = cnt_ff;
   assign rsp_longest_suffix_len = lsl_ff;
   assign rsp_new_palindrome     = newp_ff;
   assign rsp_overflow           = ovf_ff;

endmodule

### design/ptree_ctrl.sv
// Controller state machine of the palindromic tree.
module ptree_ctrl
   import ptree_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_START, ST_CHECK, ST_WALK, ST_WALK2, ST_WALK3,
      ST_FOUND, ST_CREAD, ST_CHK, ST_NREAD, ST_DREAD, ST_FIN, ST_RESP
   } state_type;

   state_type    state_ff, state_in;
   logic         phase_ff, phase_in;
   logic         resume_ff, resume_in;
   logic         rsp_valid_ff, rsp_valid_in;
   res_kind_type kind_ff, kind_in;
   logic         slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      resume_in    = resume_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.node_src = NSRC_V;
      cmd.kind     = kind_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) state_in = resume_ff ? ST_CHECK : ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_CHECK;
            if (sts.restart) begin
               cmd.do_restart = 1'b1;
               if (sts.wrap) begin
                  cmd.clear_start = 1'b1;
                  resume_in       = 1'b1;
                  state_in        = ST_CLEAR;
               end
            end
         end
         ST_CHECK: begin
            if (sts.bad) begin
               kind_in  = RES_OVF;
               state_in = ST_RESP;
            end else begin
               cmd.start_item = 1'b1;
               phase_in       = 1'b0;
               state_in       = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.rd_node = 1'b1;
            state_in    = ST_WALK2;
         end
         ST_WALK2: begin
            if (sts.len_root) begin
               state_in = ST_FOUND;
            end else if (sts.back_ok) begin
               cmd.rd_text = 1'b1;
               state_in    = ST_WALK3;
            end else begin
               cmd.follow_link = 1'b1;
               state_in        = ST_WALK;
            end
         end
         ST_WALK3: begin
            if (sts.text_match) begin
               state_in = ST_FOUND;
            end else begin
               cmd.follow_link = 1'b1;
               state_in        = ST_WALK;
            end
         end
         ST_FOUND: begin
            cmd.calc_key = 1'b1;
            cmd.set_cur  = !phase_ff;
            state_in     = ST_CREAD;
         end
         ST_CREAD: begin
            cmd.rd_child = 1'b1;
            state_in     = ST_CHK;
         end
         ST_CHK: begin
            if (phase_ff) begin
               cmd.take_link = 1'b1;
               state_in      = ST_DREAD;
            end else if (sts.child_hit) begin
               cmd.take_child = 1'b1;
               state_in       = ST_NREAD;
            end else begin
               cmd.create = 1'b1;
               if (sts.cur_odd) begin
                  state_in = ST_DREAD;
               end else begin
                  cmd.walk_up = 1'b1;
                  phase_in    = 1'b1;
                  state_in    = ST_WALK;
               end
            end
         end
         ST_NREAD: begin
            cmd.rd_node  = 1'b1;
            cmd.node_src = NSRC_NODE;
            kind_in      = RES_OLD;
            state_in     = ST_RESP;
         end
         ST_DREAD: begin
            cmd.rd_node  = 1'b1;
            cmd.node_src = NSRC_LINK;
            state_in     = ST_FIN;
         end
         ST_FIN: begin
            cmd.commit = 1'b1;
            kind_in    = RES_NEW;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= 1'b0;
         resume_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= RES_OVF;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         resume_ff    <= resume_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
      end
   end

endmodule

### design/palindromic_tree_append_core.sv
// Top level of the palindromic tree append block.
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   req     | in        | req_valid, req_stall, req_symbol, req_restart
//   rsp     | out       | rsp_valid, rsp_stall, rsp_suffix_count,
//           |           | rsp_longest_suffix_len, rsp_new_palindrome, rsp_overflow
//
// After acceptance a transaction walks the suffix-link candidates, reading each node and,
// where the palindrome can be wrapped, comparing a text symbol; a new node needs a
// second walk for its suffix link unless its parent is the imaginary root. A refused
// symbol skips the walk. The block returns to idle before the next acceptance.
// After reset, and on every sixteenth restart, a clearing pass sweeps the child table.
// A result waits in the output register while the next transaction is accepted; the
// controller holds in its result state while it is full and stalled.
module palindromic_tree_append_core
   import ptree_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [SYM_W-1:0]   req_symbol,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [OUT_W-1:0]   rsp_suffix_count,
   output logic [OUT_W-1:0]   rsp_longest_suffix_len,
   output logic               rsp_new_palindrome,
   output logic               rsp_overflow
);

   cmd_type cmd;
   sts_type sts;

   // Controller.
   ptree_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath.
   ptree_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .req_symbol             (req_symbol),
      .req_restart            (req_restart),
      .cmd                    (cmd),
      .sts                    (sts),
      .rsp_suffix_count       (rsp_suffix_count),
      .rsp_longest_suffix_len (rsp_longest_suffix_len),
      .rsp_new_palindrome     (rsp_new_palindrome),
      .rsp_overflow           (rsp_overflow)
   );

endmodule

### verif/tb.sv
// Self-checking testbench for the palindromic tree append block.
`timescale 1ns / 100ps

module tb;
   import ptree_pkg::*;

   localparam int EVEN_ROOT  = 0;
   localparam int ODD_ROOT   = 1;
   localparam int CYCLE_CAP  = 2000000;
   localparam int DRAIN_WAIT = 200;
   localparam int HOLD_LEN   = 600;

   typedef struct {
      logic [OUT_W-1:0] count;
      logic [OUT_W-1:0] len;
      logic             fresh;
      logic             ovf;
   } suffix_info_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [SYM_W-1:0]   req_symbol;
   logic               req_restart;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [OUT_W-1:0]   rsp_suffix_count;
   logic [OUT_W-1:0]   rsp_longest_suffix_len;
   logic               rsp_new_palindrome;
   logic               rsp_overflow;

   // Shadow copy of the tree, updated as each transaction is accepted.
   byte unsigned text_buf[0:MAX_LEN];
   int           pal_len[0:NODE_CAP-1];
   int           pal_link[0:NODE_CAP-1];
   int           pal_depth[0:NODE_CAP-1];
   int           edge_to[0:NODE_CAP*ALPHABET-1];
   int           tail_node;
   int           text_len;
   int           node_cnt;

   suffix_info_type pending_suffix[$];
   int           mismatches;
   int           sent_cnt;
   int           checked_cnt;
   int           restart_cnt;
   int           overflow_cnt;
   int           created_cnt;
   int           burst_left;
   int           hold_req_cnt;
   int           hold_seen;
   int           hold_cycles;
   int           cycle_cnt;

   palindromic_tree_append_core u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_symbol             (req_symbol),
      .req_restart            (req_restart),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_suffix_count       (rsp_suffix_count),
      .rsp_longest_suffix_len (rsp_longest_suffix_len),
      .rsp_new_palindrome     (rsp_new_palindrome),
      .rsp_overflow           (rsp_overflow)
   );

   // Clock generation.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Return the tree to its empty state.
   task automatic clear_tree();
      for (int i = 0; i <= MAX_LEN; i++) text_buf[i] = 0;
      for (int i = 0; i < NODE_CAP; i++) begin
         pal_len[i] = 0;
         pal_link[i] = 0;
         pal_depth[i] = 0;
      end
      for (int i = 0; i < NODE_CAP * ALPHABET; i++) edge_to[i] = 0;
      pal_len[ODD_ROOT] = -1;
      pal_link[EVEN_ROOT] = ODD_ROOT;
      pal_link[ODD_ROOT] = ODD_ROOT;
      tail_node = EVEN_ROOT;
      text_len = 0;
      node_cnt = 2;
   endtask

   // Follow suffix links until the palindrome can be wrapped by the newest symbol.
   function automatic int find_mirror(int v);
      int back;
      while (1) begin
         if (v >= NODE_CAP) v = ODD_ROOT;
         back = text_len - pal_len[v] - 1;
         if (back == text_len) return v;
         if (back >= 1 && back <= MAX_LEN && text_buf[back] == text_buf[text_len]) return v;
         v = pal_link[v];
      end
      return v;
   endfunction

   // Append one symbol to the shadow tree and queue the expected transaction.
   task automatic append_symbol(logic [SYM_W-1:0] sym, logic restart);
      suffix_info_type exp;
      int           cur;
      int           key;
      int           node;
      int           up;
      exp = '{count: '0, len: '0, fresh: 1'b0, ovf: 1'b0};
      if (restart) begin
         clear_tree();
         restart_cnt++;
      end
      if (sym < 1 || sym > ALPHABET || text_len >= MAX_LEN || node_cnt >= NODE_CAP) begin
         exp.ovf = 1'b1;
         overflow_cnt++;
      end else begin
         text_len++;
         text_buf[text_len] = sym;
         cur = find_mirror(tail_node);
         key = cur * ALPHABET + int'(sym) - 1;
         node = edge_to[key];
         if (node == 0) begin
            node = node_cnt++;
            pal_len[node] = pal_len[cur] + 2;
            if (cur == ODD_ROOT) begin
               pal_link[node] = EVEN_ROOT;
            end else begin
               up = find_mirror(pal_link[cur]);
               pal_link[node] = edge_to[up * ALPHABET + int'(sym) - 1];
            end
            pal_depth[node] = pal_depth[pal_link[node]] + 1;
            edge_to[key] = node;
            exp.fresh = 1'b1;
            created_cnt++;
         end
         tail_node = node;
         exp.count = OUT_W'(pal_depth[node]);
         exp.len = OUT_W'(pal_len[node]);
      end
      pending_suffix = {pending_suffix, exp};
   endtask

   // Offer one symbol and hold it until accepted; called at a rising edge.
   task automatic send_symbol(logic [SYM_W-1:0] sym, logic restart, bit idle_ok = 1);
      int gap;
      req_valid <= 1'b1;
      req_symbol <= sym;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      append_symbol(sym, restart);
      sent_cnt++;
      // Bursts of random length separated by random gaps.
      if (idle_ok) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_word(string s, bit restart);
      for (int i = 0; i < s.len(); i++)
         send_symbol(SYM_W'(s[i] - "a" + 1), (i == 0) ? restart : 1'b0);
   endtask

   // Known words, alphabet extremes and the out-of-range codes 0, 27 and 31.
   task automatic test_directed();
      send_word("abacaba", 1'b1);
      send_word("zz", 1'b0);
      send_symbol(SYM_W'(0), 1'b0);
      send_symbol(SYM_W'(27), 1'b0);
      send_symbol(SYM_W'(31), 1'b1);
      send_word("aabbaa", 1'b0);
      send_symbol(SYM_W'(ALPHABET), 1'b1);
      send_symbol(SYM_W'(1), 1'b0);
      send_symbol(SYM_W'(ALPHABET), 1'b0);
   endtask

   // Random strings over small alphabets and at times the full one, with occasional restarts and bad codes.
   task automatic test_random(int n);
      int          span;
      logic [SYM_W-1:0] sym;
      span = 2;
      for (int i = 0; i < n; i++) begin
         if (i % 50 == 0) span = $urandom_range(2, 4);
         if (i % 97 == 0) span = ALPHABET;
         sym = SYM_W'($urandom_range(1, span));
         if ($urandom_range(0, 39) == 0) sym = SYM_W'($urandom_range(27, 31));
         if ($urandom_range(0, 59) == 0) sym = '0;
         if (i == n / 2) hold_req_cnt++;
         send_symbol(sym, ($urandom_range(0, 39) == 0));
      end
   endtask

   // Receiver stall pattern, with a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_req_cnt) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= HOLD_LEN - 1;
         hold_seen   <= hold_req_cnt;
      end else if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         case ((cycle_cnt / 2048) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 9) < 6);
            default: rsp_stall <= ((cycle_cnt % 5) < 2);
         endcase
      end
   end

   // Compare each accepted result transaction with the oldest expectation.
   always @(posedge clock) begin
      suffix_info_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_cnt++;
         if (pending_suffix.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: count %0d len %0d new %0b ovf %0b",
                        rsp_suffix_count, rsp_longest_suffix_len,
                        rsp_new_palindrome, rsp_overflow);
         end else begin
            exp = pending_suffix.pop_front();
            if (rsp_suffix_count !== exp.count || rsp_longest_suffix_len !== exp.len ||
                rsp_new_palindrome !== exp.fresh || rsp_overflow !== exp.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch #%0d: exp count %0d len %0d new %0b ovf %0b,",
                            " got %0d %0d %0b %0b"},
                           checked_cnt, exp.count, exp.len, exp.fresh, exp.ovf,
                           rsp_suffix_count, rsp_longest_suffix_len,
                           rsp_new_palindrome, rsp_overflow);
            end
         end
      end
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d transactions outstanding",
                  cycle_cnt, pending_suffix.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int drain;
      reset = 1'b1;
      req_valid = 1'b0;
      req_symbol = '0;
      req_restart = 1'b0;
      hold_req_cnt = 0;
      sent_cnt = 0;
      restart_cnt = 0;
      overflow_cnt = 0;
      created_cnt = 0;
      burst_left = 5;
      clear_tree();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(370);
      req_valid <= 1'b0;

      // Drain outstanding results, then allow stray ones to show up.
      while (pending_suffix.size() != 0) @(posedge clock);
      drain = DRAIN_WAIT;
      while (drain > 0) begin
         @(posedge clock);
         drain--;
      end

      $display("sent %0d symbols, checked %0d results, %0d new nodes", sent_cnt,
               checked_cnt, created_cnt);
      $display("%0d restarts, %0d refused symbols, %0d mismatches", restart_cnt,
               overflow_cnt, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
